### rtl/mgrad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrad_pkg
// shared types and constants of the 3x3 rgb morphological gradient block
// ----------------------------------------------------------------------------
package mgrad_pkg;

    // operation codes of an input word
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int WIDTH_REG_W      = 11;
    localparam int HEIGHT_REG_W     = 13;
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic       operation;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_word;

    typedef struct packed {
        logic [7:0] grad_red;
        logic [7:0] grad_green;
        logic [7:0] grad_blue;
        logic       row_end;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // one line store entry: rows r-2 and r-1 of a column
    typedef struct packed {
        t_pix upper;
        t_pix lower;
    } t_line;

    typedef struct packed {
        logic [7:0] mx;
        logic [7:0] mn;
    } t_mm;

    // vertical max/min of one window column, per channel
    typedef struct packed {
        t_mm red;
        t_mm green;
        t_mm blue;
    } t_colmm;

    // control flags that travel with an item through the pipe
    typedef struct packed {
        logic prod;
        logic top_ok;
        logic bot_ok;
        logic vc_left;
        logic vc_right;
        logic row_end;
        logic frame_end;
    } t_flags;

endpackage

### rtl/morphological_gradient_3x3_rgb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morphological_gradient_3x3_rgb_top
// per-channel 3x3 max minus min of a raster rgb stream, clipped at borders
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall / i_in_word): one word per pixel in
//   raster order; operation selects pixel or drain. after the last pixel of a
//   frame, drain words push out the last image_width+1 results. a drain that
//   arrives before the last pixel of a frame is dropped.
//   output channel (o_out_valid / i_out_stall / o_out_word): one result per
//   pixel in raster order, with row_end and frame_end marks.
//   config channel (i_cfg_valid / o_cfg_ready): index 0 image_width, index 1
//   image_height; ready is always high. a write restarts the frame; write
//   only while the block is idle.
//   throughput: one word per cycle while o_in_stall is low. the line store
//   entry of a word's column is read at the edge that accepts it; its
//   result (if any) passes stage 1 and stage 2 into the result queue, and
//   belongs to the pixel that arrived image_width+1 words earlier.
//   a small result queue decouples the sides: while the receiver stalls the
//   block keeps accepting until queue plus in-flight words fill it.
//   reset clears counters and the queue; line stores are not cleared, and
//   entries not yet written in a frame are read but masked out of results.
// ----------------------------------------------------------------------------
module morphological_gradient_3x3_rgb_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  mgrad_pkg::t_in_word                   i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output mgrad_pkg::t_out_word                  o_out_word,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mgrad_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mgrad_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mgrad_pkg::*;

    // counter widths
    localparam int AW  = $clog2(MAX_WIDTH);       // column index
    localparam int CW  = $clog2(MAX_WIDTH + 1);   // width value
    localparam int OHW = $clog2(MAX_HEIGHT);      // output row index
    localparam int HW  = $clog2(MAX_HEIGHT + 1);  // height value
    localparam int RW  = $clog2(MAX_HEIGHT + 2);  // input row, runs one past height on drain
    localparam int RST_W = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;

    // masked vertical max/min of one channel; the centre row always counts
    function automatic t_mm chan_reduce(input logic [7:0] top, input logic [7:0] mid,
                                        input logic [7:0] bot, input logic top_ok,
                                        input logic bot_ok);
        t_mm res;
        res.mx = mid;
        res.mn = mid;
        if (top_ok && (top > res.mx)) res.mx = top;
        if (top_ok && (top < res.mn)) res.mn = top;
        if (bot_ok && (bot > res.mx)) res.mx = bot;
        if (bot_ok && (bot < res.mn)) res.mn = bot;
        return res;
    endfunction

    // horizontal merge of three column results, then max minus min
    function automatic logic [7:0] chan_merge(input t_mm lft, input t_mm ctr, input t_mm rgt,
                                              input logic vl, input logic vr);
        logic [7:0] mx;
        logic [7:0] mn;
        mx = ctr.mx;
        mn = ctr.mn;
        if (vl && (lft.mx > mx)) mx = lft.mx;
        if (vl && (lft.mn < mn)) mn = lft.mn;
        if (vr && (rgt.mx > mx)) mx = rgt.mx;
        if (vr && (rgt.mn < mn)) mn = rgt.mn;
        return mx - mn;
    endfunction

    // configuration, held as clamped effective values
    logic [CW-1:0]  r_eff_w, n_eff_w;
    logic [HW-1:0]  r_eff_h, n_eff_h;

    // stream position counters
    logic [AW-1:0]  r_in_col, n_in_col;
    logic [RW-1:0]  r_in_row, n_in_row;
    logic [AW-1:0]  r_out_col, n_out_col;
    logic [OHW-1:0] r_out_row, n_out_row;

    // accept stage decode
    logic   in_accept;
    logic   cfg_write;
    logic   frame_done;
    logic   item_take;
    logic   col_last;
    logic   ocol_last;
    logic   orow_last;
    t_flags n_flags;
    t_pix   n_px;

    // line store (rows r-2 and r-1), read at accept, written in the cycle after
    t_line          r_line_mem [MAX_WIDTH];
    t_line          r_rd;
    logic           r_byp;
    t_line          r_byp_data;
    t_line          s1_line;
    t_line          s1_wdata;

    // stage 1: column reduce
    logic           r_v1;
    logic [AW-1:0]  r_s1_addr;
    t_pix           r_s1_px;
    t_flags         r_s1_flg;
    t_colmm         s1_col;

    // window of three reduced columns: left, centre, right
    t_colmm         r_win [3];

    // stage 2: horizontal merge into the queue
    logic           r_v2;
    t_flags         r_s2_flg;
    t_out_word      s2_word;

    // result queue
    t_out_word             r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fifo_cnt;
    logic [FIFO_CNT_W:0]   fill;
    logic                  out_pop;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    // stall when the queue could not take every word already in flight
    assign fill = (FIFO_CNT_W + 1)'(r_fifo_cnt) + (FIFO_CNT_W + 1)'(r_v1)
                + (FIFO_CNT_W + 1)'(r_v2);
    assign o_in_stall = (fill >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // accept stage: counters and per-item flags
    // ------------------------------------------------------------------
    always_comb begin
        frame_done = (r_in_row >= RW'(r_eff_h));
        // a drain before the frame end is dropped
        item_take  = in_accept && !((i_in_word.operation == OP_DRAIN) && !frame_done);
        col_last   = ((CW'(r_in_col) + CW'(1)) == r_eff_w);
        ocol_last  = ((CW'(r_out_col) + CW'(1)) == r_eff_w);
        orow_last  = ((HW'(r_out_row) + HW'(1)) == r_eff_h);

        // pixel samples past the frame end count as zero
        n_px = frame_done ? t_pix'('0)
                          : t_pix'{red: i_in_word.in_red, green: i_in_word.in_green,
                                   blue: i_in_word.in_blue};

        // no result until row 1 column 1 has arrived
        n_flags.prod      = !((r_in_row == '0) || ((r_in_row == RW'(1)) && (r_in_col == '0)));
        n_flags.top_ok    = (r_in_row >= RW'(2));
        n_flags.bot_ok    = !frame_done;
        n_flags.vc_left   = (r_out_col != '0);
        n_flags.vc_right  = !ocol_last;
        n_flags.row_end   = ocol_last;
        n_flags.frame_end = ocol_last && orow_last;

        n_eff_w   = r_eff_w;
        n_eff_h   = r_eff_h;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;

        if (cfg_write) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) begin
                if (i_cfg_data[WIDTH_REG_W-1:0] == '0) begin
                    n_eff_w = CW'(1);
                end else if (32'(i_cfg_data[WIDTH_REG_W-1:0]) > 32'(MAX_WIDTH)) begin
                    n_eff_w = CW'(MAX_WIDTH);
                end else begin
                    n_eff_w = CW'(i_cfg_data[WIDTH_REG_W-1:0]);
                end
            end
            if (i_cfg_index == REG_IMAGE_HEIGHT) begin
                if (i_cfg_data[HEIGHT_REG_W-1:0] == '0) begin
                    n_eff_h = HW'(1);
                end else if (32'(i_cfg_data[HEIGHT_REG_W-1:0]) > 32'(MAX_HEIGHT)) begin
                    n_eff_h = HW'(MAX_HEIGHT);
                end else begin
                    n_eff_h = HW'(i_cfg_data[HEIGHT_REG_W-1:0]);
                end
            end
            // any write restarts the frame
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (item_take) begin
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + AW'(1);
            end
            if (n_flags.prod) begin
                if (n_flags.frame_end) begin
                    // last result of the frame: start over
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (ocol_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + OHW'(1);
                end else begin
                    n_out_col = r_out_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w   <= CW'(RST_W);
            r_eff_h   <= HW'(RST_H);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_eff_w   <= n_eff_w;
            r_eff_h   <= n_eff_h;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ------------------------------------------------------------------
    // line store: read-first, one write per item in stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_line_mem[r_s1_addr] <= s1_wdata;
        end
        if (item_take) begin
            r_rd <= r_line_mem[r_in_col];
        end
    end

    // forward the entry being written when the next word reads the same column
    assign s1_line  = r_byp ? r_byp_data : r_rd;
    assign s1_wdata = t_line'{upper: s1_line.lower, lower: r_s1_px};

    always_ff @(posedge i_clk) begin
        if (item_take) begin
            r_byp_data <= s1_wdata;
            r_s1_addr  <= r_in_col;
            r_s1_px    <= n_px;
            r_s1_flg   <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_byp <= 1'b0;
        end else begin
            r_v1  <= item_take;
            r_byp <= item_take && r_v1 && (r_s1_addr == r_in_col);
        end
    end

    // ------------------------------------------------------------------
    // stage 1: vertical reduce of the new column, shift the window
    // ------------------------------------------------------------------
    always_comb begin
        s1_col.red   = chan_reduce(s1_line.upper.red, s1_line.lower.red, r_s1_px.red,
                                   r_s1_flg.top_ok, r_s1_flg.bot_ok);
        s1_col.green = chan_reduce(s1_line.upper.green, s1_line.lower.green, r_s1_px.green,
                                   r_s1_flg.top_ok, r_s1_flg.bot_ok);
        s1_col.blue  = chan_reduce(s1_line.upper.blue, s1_line.lower.blue, r_s1_px.blue,
                                   r_s1_flg.top_ok, r_s1_flg.bot_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (r_v1) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= s1_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_s2_flg <= r_s1_flg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1 && r_s1_flg.prod;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: horizontal merge, border columns masked
    // ------------------------------------------------------------------
    always_comb begin
        s2_word.grad_red   = chan_merge(r_win[0].red, r_win[1].red, r_win[2].red,
                                        r_s2_flg.vc_left, r_s2_flg.vc_right);
        s2_word.grad_green = chan_merge(r_win[0].green, r_win[1].green, r_win[2].green,
                                        r_s2_flg.vc_left, r_s2_flg.vc_right);
        s2_word.grad_blue  = chan_merge(r_win[0].blue, r_win[1].blue, r_win[2].blue,
                                        r_s2_flg.vc_left, r_s2_flg.vc_right);
        s2_word.row_end    = r_s2_flg.row_end;
        s2_word.frame_end  = r_s2_flg.frame_end;
    end

    // ------------------------------------------------------------------
    // result queue
    // ------------------------------------------------------------------
    assign o_out_valid = (r_fifo_cnt != '0);
    assign o_out_word  = r_fifo[r_rd_ptr];
    assign out_pop     = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_fifo[r_wr_ptr] <= s2_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (r_v2) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (r_v2 && !out_pop) begin
                r_fifo_cnt <= r_fifo_cnt + FIFO_CNT_W'(1);
            end else if (!r_v2 && out_pop) begin
                r_fifo_cnt <= r_fifo_cnt - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

### rtl/mgrad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrad_checker
// port-level checks of the gradient block, bound to the top level
// ----------------------------------------------------------------------------
module mgrad_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input mgrad_pkg::t_out_word o_out_word
);
    import mgrad_pkg::*;

    // a stalled word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output word withdrawn while stalled");

    // a stalled word keeps its value
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // the last pixel of a frame is also the last of its row
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.frame_end) |-> o_out_word.row_end)
        else $error("frame end without row end");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind morphological_gradient_3x3_rgb_top mgrad_checker u_mgrad_checker (.*);

### tb/sv/tb_morphological_gradient_3x3_rgb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morphological_gradient_3x3_rgb_top
// self-checking bench for the 3x3 rgb morphological gradient block
// ----------------------------------------------------------------------------
// every accepted input word runs through a behavioral model of the line
// stores and the 3x3 window. that model queues the gradient words the block
// must produce, and each accepted output word is checked against the oldest
// one. the stimulus starts with tiny hand-built frames (clamped sizes, drains
// inside and after a frame, saturated samples), continues with a partial
// frame at the clamped maximum width, then with randomly sized frames. both
// channel sides pause at random, and once the output side holds off long
// enough for the block to fill and stall its input
// ----------------------------------------------------------------------------
module tb_morphological_gradient_3x3_rgb_top;
    import mgrad_pkg::*;

    localparam int LINE_DEPTH   = 1024;   // line store depth, widest row
    localparam int ROWS_MAX     = 4096;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 780;    // random part; directed frames add about 1070
    localparam int CALM_ITEMS   = 200;    // tail of the run without pauses
    localparam int SETTLE_WAIT  = 12;     // covers stage 1 and stage 2 of the pipe plus margin
    localparam int LONG_HOLD    = 80;
    localparam int QUIET_LIMIT  = 3000;   // cycles with no handshake at all

    typedef enum int {FILL_NOISE, FILL_BINARY, FILL_FLAT} t_fill;

    // ------------------------------------------------------------------------
    // gradient model and expected word store
    // ------------------------------------------------------------------------
    class gradient_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        t_pix        upper_line [LINE_DEPTH];   // row r-2 per column
        t_pix        lower_line [LINE_DEPTH];   // row r-1 per column
        t_pix        win [3][3];                // [left, centre, right][top, mid, bottom]
        int unsigned in_col;
        int unsigned in_row;
        int unsigned out_pos;
        t_out_word   expected_grads [$];
        int unsigned mismatches;

        function new();
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i, j]) win[i][j] = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_pos = 0;
        endfunction

        // out-of-range sizes are clamped into 1..max
        function int unsigned cols();
            if (width_reg < 1) return 1;
            if (width_reg > LINE_DEPTH) return LINE_DEPTH;
            return width_reg;
        endfunction

        function int unsigned rows();
            if (height_reg < 1) return 1;
            if (height_reg > ROWS_MAX) return ROWS_MAX;
            return height_reg;
        endfunction

        function int pending();
            return expected_grads.size();
        endfunction

        // any register write restarts the frame
        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_IMAGE_WIDTH)
                width_reg = 32'(data[WIDTH_REG_W-1:0]);
            else if (index == REG_IMAGE_HEIGHT)
                height_reg = 32'(data[HEIGHT_REG_W-1:0]);
            restart();
        endfunction

        function void note_pixel_word(t_in_word word);
            int unsigned w;
            int unsigned h;
            int unsigned seq;
            int unsigned r;
            int unsigned c;
            int unsigned col;
            bit          done;
            bit          row_ok [3];
            bit          col_ok [3];
            t_pix        px;
            t_out_word   res;
            logic [7:0]  hi [3];
            logic [7:0]  lo [3];
            logic [7:0]  chan [3];

            w    = cols();
            h    = rows();
            done = (in_row >= h);
            // drain inside a frame, or with nothing left to flush
            if (word.operation == OP_DRAIN && !done) return;
            // past frame end a pixel only pushes the window along
            px = '0;
            if (!done) begin
                px.red   = word.in_red;
                px.green = word.in_green;
                px.blue  = word.in_blue;
            end
            col = in_col;
            if (col >= LINE_DEPTH) col = 0;

            for (int i = 0; i < 3; i++) begin
                win[0][i] = win[1][i];
                win[1][i] = win[2][i];
            end
            win[2][0]       = upper_line[col];
            win[2][1]       = lower_line[col];
            win[2][2]       = px;
            upper_line[col] = lower_line[col];
            lower_line[col] = px;

            seq = in_row * w + in_col;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            // the window centre trails the input by one row and one column
            if (seq < w + 1) return;

            r = out_pos / w;
            c = out_pos % w;
            row_ok[0] = (r > 0);
            row_ok[1] = 1'b1;
            row_ok[2] = (r + 1 < h);
            col_ok[0] = (c > 0);
            col_ok[1] = 1'b1;
            col_ok[2] = (c + 1 < w);

            for (int ch = 0; ch < 3; ch++) begin
                hi[ch] = 8'h00;
                lo[ch] = 8'hFF;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (col_ok[i] && row_ok[j]) begin
                        chan[0] = win[i][j].red;
                        chan[1] = win[i][j].green;
                        chan[2] = win[i][j].blue;
                        for (int ch = 0; ch < 3; ch++) begin
                            if (chan[ch] > hi[ch]) hi[ch] = chan[ch];
                            if (chan[ch] < lo[ch]) lo[ch] = chan[ch];
                        end
                    end
                end
            end
            res.grad_red   = hi[0] - lo[0];
            res.grad_green = hi[1] - lo[1];
            res.grad_blue  = hi[2] - lo[2];
            res.row_end    = (c + 1 == w);
            res.frame_end  = (out_pos + 1 == w * h);
            expected_grads.push_back(res);

            out_pos++;
            if (out_pos >= w * h) restart();
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_grads.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_grads.pop_front();
            if (got !== want) begin
                $display("%0t: expected %h/%h/%h/%b/%b got %h/%h/%h/%b/%b", $time,
                         want.grad_red, want.grad_green, want.grad_blue,
                         want.row_end, want.frame_end,
                         got.grad_red, got.grad_green, got.grad_blue,
                         got.row_end, got.frame_end);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    gradient_scoreboard sb;
    bit idle_on     = 1'b1;   // random pauses on both sides
    bit hold_asked  = 1'b0;   // set by the stimulus, served once by the sink
    bit hold_given  = 1'b0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    morphological_gradient_3x3_rgb_top #(
        .MAX_WIDTH  (LINE_DEPTH),
        .MAX_HEIGHT (ROWS_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // handshake monitor: samples pre-edge values, feeds the model and checks
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) sb.note_pixel_word(i_in_word);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_word);
        end
    end

    // ------------------------------------------------------------------------
    // output side: short random stalls, and one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_asked && !hold_given) begin
                hold_given = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any handshake means the block hung
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // word builders and drivers
    // ------------------------------------------------------------------------
    function automatic t_in_word pix_word(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        t_in_word word;
        word.operation = OP_PIXEL;
        word.in_red    = r;
        word.in_green  = g;
        word.in_blue   = b;
        return word;
    endfunction

    // samples of a drain are don't-care, so they are random
    function automatic t_in_word drain_word();
        t_in_word word;
        word           = pix_word(8'($urandom), 8'($urandom), 8'($urandom));
        word.operation = OP_DRAIN;
        return word;
    endfunction

    function automatic t_in_word random_pixel(input t_fill fill);
        case (fill)
            FILL_NOISE:  return pix_word(8'($urandom), 8'($urandom), 8'($urandom));
            // saturated samples give full-scale gradients
            FILL_BINARY: return pix_word({8{1'($urandom)}}, {8{1'($urandom)}},
                                         {8{1'($urandom)}});
            default:     return pix_word(8'($urandom_range(96, 99)),
                                         8'($urandom_range(96, 99)),
                                         8'($urandom_range(96, 99)));
        endcase
    endfunction

    // holds the word until accepted, valid stays up between back-to-back words
    task automatic send_word(input t_in_word word);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= word;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and wait until every expected word is out and the pipe is empty
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] width_data,
                             input logic [CFG_DATA_W-1:0] height_data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= width_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= height_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int    fed;
        int    w;
        int    h;
        int    wreg;
        int    hreg;
        int    nframes;
        int    npx;
        bit    abort;
        bit    hold_phase;
        t_fill fill;

        sb  = new();
        fed = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sizes count as one: a single-pixel frame, flushed by two drains
        set_frame('0, '0);
        send_word(pix_word(8'hFF, 8'h00, 8'hFF));
        send_word(drain_word());
        send_word(drain_word());
        send_word(drain_word());   // frame already restarted, dropped

        // 2x2 frame with a drain inside it and a pixel word used as a drain
        set_frame(13'd2, 13'd2);
        send_word(pix_word(8'h00, 8'hFF, 8'h00));
        send_word(drain_word());   // inside the frame, dropped
        send_word(pix_word(8'hFF, 8'h00, 8'hFF));
        send_word(pix_word(8'hFF, 8'hFF, 8'h00));
        send_word(pix_word(8'h00, 8'h00, 8'hFF));
        send_word(pix_word(8'h5A, 8'hA5, 8'h3C));   // after frame end, samples lost
        send_word(drain_word());
        send_word(drain_word());

        // 3x3 frame of saturated samples, different pattern per channel
        set_frame(13'd3, 13'd3);
        for (int i = 0; i < 9; i++)
            send_word(pix_word(i[0] ? 8'hFF : 8'h00, (i < 3) ? 8'hFF : 8'h00,
                               (i % 3 == 1) ? 8'hFF : 8'h00));
        for (int k = 0; k < 4; k++) send_word(drain_word());

        // all-ones register data clamps to the widest row and tallest frame;
        // a partial frame, dropped by the next register write
        set_frame('1, '1);
        for (int p = 0; p < LINE_DEPTH + 16; p++) send_word(random_pixel(FILL_NOISE));

        // randomly sized frames, back to back within a setting
        while (fed < RANDOM_ITEMS) begin
            hold_phase = !hold_asked && fed >= 300;
            if (hold_phase) begin
                // big enough to fill the block while the output is held off
                wreg = 8;
                hreg = 8;
            end else begin
                wreg = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                  : $urandom_range(7, 24);
                hreg = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                  : $urandom_range(7, 12);
                if ($urandom_range(0, 19) == 0) wreg = 0;
                if ($urandom_range(0, 19) == 0) hreg = 0;
            end
            w       = (wreg == 0) ? 1 : wreg;
            h       = (hreg == 0) ? 1 : hreg;
            nframes = $urandom_range(1, 3);
            fill    = t_fill'($urandom_range(0, 2));

            set_frame(13'(wreg), 13'(hreg));
            if (fed >= RANDOM_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            if (hold_phase) hold_asked = 1'b1;

            for (int f = 0; f < nframes; f++) begin
                // sometimes cut the last frame short, the next write drops it
                abort = (f == nframes - 1) && !hold_phase && ($urandom_range(0, 7) == 0);
                npx   = abort ? $urandom_range(1, w * h) : w * h;
                for (int p = 0; p < npx; p++) begin
                    if ($urandom_range(0, 9) == 0) send_word(drain_word());
                    send_word(random_pixel(fill));
                    fed++;
                end
                if (!abort) begin
                    // flush: one row plus one word, drains or stray pixels
                    for (int k = 0; k <= w; k++) begin
                        send_word(($urandom_range(0, 4) == 0) ? random_pixel(fill)
                                                              : drain_word());
                        fed++;
                    end
                    if ($urandom_range(0, 3) == 0) send_word(drain_word());
                end
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
